FILE: src/scsc_pkg.sv
// Package for the sparse CSC matrix store: shared types and constants.
// No dependencies.
`timescale 1ns / 1ps
package scsc_pkg;
   localparam logic ACT_READ  = 1'b0;
   localparam logic ACT_WRITE = 1'b1;
   localparam logic STAT_DONE = 1'b0;
   localparam logic STAT_FULL = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PTR0,
      ST_PTR1,
      ST_SCAN,
      ST_SCAN_CHK,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_INSERT,
      ST_BUMP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic ptr_rd_first;
      logic ptr_rd_last;
      logic ptr_cap_first;
      logic ptr_cap_last;
      logic scan_step;
      logic found;
      logic set_pos;
      logic shift_init;
      logic shift_rd;
      logic shift_wr;
      logic insert;
      logic bump_init;
      logic bump_step;
      logic respond;
      logic full;
   } cmd_type;

   typedef struct packed {
      logic is_write;
      logic in_range;
      logic full;
      logic scan_done;
      logic hit;
      logic greater;
      logic shift_done;
      logic bump_done;
      logic clearing;
   } stat_type;
endpackage

FILE: src/sparse_csc_matrix_store_core.sv
// Top level of the sparse CSC matrix store.
// Depends on scsc_pkg, scsc_ctrl and scsc_dp.
//
// channel | ports                                   | direction
// req     | start, busy, req_action/row/column/value | in
// rsp     | rsp_strobe, rsp_read_value, rsp_status   | out
//
// One item at a time. A read scans the entries of its column; a write also
// shifts later entries (a read state, then a write state, per entry) and bumps
// every later column pointer (one per cycle). After reset the pointer memory
// (MAX_COLUMNS+1 entries) is cleared; busy stays high meanwhile.
// The receiver cannot stall; one strobe per item.
`timescale 1ns / 1ps
module sparse_csc_matrix_store_core #(
   parameter int MAX_COLUMNS = 1024,
   parameter int MAX_ROWS    = 1024,
   parameter int MAX_ENTRIES = 4096,
   parameter int VALUE_BITS  = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_action,
   input  logic [9:0]         req_row,
   input  logic [9:0]         req_column,
   input  logic signed [31:0] req_value,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_read_value,
   output logic               rsp_status
);
   scsc_pkg::cmd_type  cmd;
   scsc_pkg::stat_type stat;
   logic               ctrl_busy;

   scsc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (ctrl_busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   scsc_dp #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS),
      .MAX_ENTRIES (MAX_ENTRIES),
      .VALUE_BITS  (VALUE_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_action     (req_action),
      .req_row        (req_row),
      .req_column     (req_column),
      .req_value      (req_value),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_strobe     (rsp_strobe)
   );

   assign busy = ctrl_busy;
endmodule

FILE: src/scsc_ctrl.sv
// Controller state machine of the sparse CSC store.
// Depends on scsc_pkg.
`timescale 1ns / 1ps
module scsc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  scsc_pkg::stat_type   stat,
   output scsc_pkg::cmd_type    cmd
);
   scsc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= scsc_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         scsc_pkg::ST_IDLE:     if (start && !stat.clearing) state_in = scsc_pkg::ST_PTR0;
         scsc_pkg::ST_PTR0: begin
            if (!stat.in_range) state_in = scsc_pkg::ST_DONE;
            else if (stat.is_write && stat.full) state_in = scsc_pkg::ST_DONE;
            else state_in = scsc_pkg::ST_PTR1;
         end
         scsc_pkg::ST_PTR1:     state_in = scsc_pkg::ST_SCAN;
         scsc_pkg::ST_SCAN: begin
            if (stat.scan_done)
               state_in = stat.is_write ? scsc_pkg::ST_SHIFT_RD : scsc_pkg::ST_DONE;
            else state_in = scsc_pkg::ST_SCAN_CHK;
         end
         scsc_pkg::ST_SCAN_CHK: begin
            if (!stat.is_write && stat.hit) state_in = scsc_pkg::ST_DONE;
            else if (stat.is_write && stat.greater) state_in = scsc_pkg::ST_SHIFT_RD;
            else state_in = scsc_pkg::ST_SCAN;
         end
         scsc_pkg::ST_SHIFT_RD:
            state_in = stat.shift_done ? scsc_pkg::ST_INSERT : scsc_pkg::ST_SHIFT_WR;
         scsc_pkg::ST_SHIFT_WR: state_in = scsc_pkg::ST_SHIFT_RD;
         scsc_pkg::ST_INSERT:   state_in = scsc_pkg::ST_BUMP;
         scsc_pkg::ST_BUMP:     if (stat.bump_done) state_in = scsc_pkg::ST_DONE;
         scsc_pkg::ST_DONE:     state_in = scsc_pkg::ST_IDLE;
         default:               state_in = scsc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = (state_ff != scsc_pkg::ST_IDLE) || stat.clearing;
      unique case (state_ff)
         scsc_pkg::ST_IDLE: begin
            cmd.load = start && !stat.clearing;
            cmd.ptr_rd_first = start && !stat.clearing;
         end
         scsc_pkg::ST_PTR0: begin
            cmd.ptr_cap_first = 1'b1;
            cmd.ptr_rd_last = 1'b1;
            cmd.full = stat.is_write && stat.full && stat.in_range;
         end
         scsc_pkg::ST_PTR1: begin
            cmd.ptr_cap_last = 1'b1;
         end
         scsc_pkg::ST_SCAN: begin
            cmd.shift_init = stat.scan_done && stat.is_write;
         end
         scsc_pkg::ST_SCAN_CHK: begin
            cmd.found = !stat.is_write && stat.hit;
            cmd.set_pos = stat.is_write && stat.greater;
            cmd.shift_init = stat.is_write && stat.greater;
            cmd.scan_step = !(stat.is_write && stat.greater) && !(!stat.is_write && stat.hit);
         end
         scsc_pkg::ST_SHIFT_RD: cmd.shift_rd = !stat.shift_done;
         scsc_pkg::ST_SHIFT_WR: cmd.shift_wr = 1'b1;
         scsc_pkg::ST_INSERT: begin
            cmd.insert = 1'b1;
            cmd.bump_init = 1'b1;
         end
         scsc_pkg::ST_BUMP:     cmd.bump_step = 1'b1;
         scsc_pkg::ST_DONE:     cmd.respond = 1'b1;
         default: ;
      endcase
   end
endmodule

FILE: src/scsc_dp.sv
// Datapath of the sparse CSC store: pointer, row and value memories.
// Depends on scsc_pkg.
`timescale 1ns / 1ps
module scsc_dp #(
   parameter int MAX_COLUMNS = 1024,
   parameter int MAX_ROWS    = 1024,
   parameter int MAX_ENTRIES = 4096,
   parameter int VALUE_BITS  = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_action,
   input  logic [9:0]          req_row,
   input  logic [9:0]          req_column,
   input  logic signed [31:0]  req_value,
   input  scsc_pkg::cmd_type   cmd,
   output scsc_pkg::stat_type  stat,
   output logic signed [31:0]  rsp_read_value,
   output logic                rsp_status,
   output logic                rsp_strobe
);
   localparam int CW = $clog2(MAX_COLUMNS + 1);
   localparam int EW = $clog2(MAX_ENTRIES + 1);
   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   // start_mem holds the start offset of each column, plus the end marker
   logic [EW-1:0]         start_mem [MAX_COLUMNS+1];
   logic [9:0]            row_mem   [MAX_ENTRIES];
   logic [VALUE_BITS-1:0] val_mem   [MAX_ENTRIES];

   logic                  act_ff;
   logic [9:0]            row_ff, col_ff;
   logic [VALUE_BITS-1:0] val_ff;
   logic [EW-1:0]         count_ff;
   logic [EW-1:0]         last_ff, idx_ff, pos_ff, sh_ff;
   logic [EW-1:0]         ptr_rd_ff;
   logic [9:0]            row_rd_ff;
   logic [VALUE_BITS-1:0] val_rd_ff;
   logic [CW:0]           bump_ff;
   logic [CW:0]           clr_ff;
   logic                  clr_busy_ff;
   logic [VALUE_BITS-1:0] res_ff;
   logic                  stat_ff, strobe_ff;
   logic [CW-1:0]         ptr_addr;
   logic [EW-1:0]         bump_val;
   logic [AW-1:0]         rd_addr;

   // pointer memory: one read port, one write port; bump uses read-modify-write
   // via a two-phase walk (read issued, then written on next cycle)
   logic                  bump_wr_ff;
   logic [CW-1:0]         bump_wa_ff;

   assign ptr_addr = cmd.ptr_rd_first ? CW'(req_column) :
                     cmd.ptr_rd_last  ? CW'({1'b0, col_ff} + 11'd1) :
                     bump_ff[CW-1:0];

   always_ff @(posedge clock) begin
      ptr_rd_ff <= start_mem[ptr_addr];
   end

   assign bump_val = ptr_rd_ff + EW'(1);

   always_ff @(posedge clock) begin
      if (clr_busy_ff) start_mem[clr_ff[CW-1:0]] <= '0;
      else if (bump_wr_ff) start_mem[bump_wa_ff] <= bump_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         clr_busy_ff <= 1'b1;
      end else if (clr_busy_ff) begin
         clr_ff <= clr_ff + 1'b1;
         if (clr_ff == (CW+1)'(MAX_COLUMNS)) clr_busy_ff <= 1'b0;
      end
   end

   assign rd_addr = cmd.shift_rd ? AW'(sh_ff - EW'(1)) : AW'(idx_ff);

   always_ff @(posedge clock) begin
      row_rd_ff <= row_mem[rd_addr];
      val_rd_ff <= val_mem[rd_addr];
      if (cmd.shift_wr) begin
         row_mem[AW'(sh_ff)] <= row_rd_ff;
         val_mem[AW'(sh_ff)] <= val_rd_ff;
      end else if (cmd.insert) begin
         row_mem[AW'(pos_ff)] <= row_ff;
         val_mem[AW'(pos_ff)] <= val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff <= req_action;
         row_ff <= req_row;
         col_ff <= req_column;
         val_ff <= VALUE_BITS'(req_value);
      end
      if (cmd.ptr_cap_first) begin
         idx_ff   <= ptr_rd_ff;
      end
      if (cmd.ptr_cap_last) begin
         last_ff <= (ptr_rd_ff > count_ff) ? count_ff : ptr_rd_ff;
         pos_ff  <= (ptr_rd_ff > count_ff) ? count_ff : ptr_rd_ff;
      end
      if (cmd.scan_step) idx_ff <= idx_ff + EW'(1);
      if (cmd.set_pos) pos_ff <= idx_ff;
      if (cmd.shift_init) sh_ff <= count_ff;
      if (cmd.shift_wr) sh_ff <= sh_ff - EW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         bump_wr_ff <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         strobe_ff  <= cmd.respond;
         bump_wr_ff <= cmd.bump_step && !stat.bump_done;
         if (cmd.insert) count_ff <= count_ff + EW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.bump_init) bump_ff <= (CW+1)'({1'b0, col_ff}) + (CW+1)'(1);
      else if (cmd.bump_step) bump_ff <= bump_ff + (CW+1)'(1);
      bump_wa_ff <= bump_ff[CW-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         res_ff  <= '0;
         stat_ff <= scsc_pkg::STAT_DONE;
      end
      if (cmd.found) res_ff <= val_rd_ff;
      if (cmd.full) stat_ff <= scsc_pkg::STAT_FULL;
   end

   always_comb begin
      stat.is_write   = (act_ff == scsc_pkg::ACT_WRITE);
      stat.in_range   = (32'(col_ff) < 32'(MAX_COLUMNS)) && (32'(row_ff) < 32'(MAX_ROWS));
      stat.full       = (32'(count_ff) >= 32'(MAX_ENTRIES));
      stat.scan_done  = (idx_ff >= last_ff);
      stat.hit        = (row_rd_ff == row_ff);
      stat.greater    = (row_rd_ff > row_ff);
      stat.shift_done = (sh_ff <= pos_ff);
      stat.bump_done  = (bump_ff > (CW+1)'(MAX_COLUMNS));
      stat.clearing   = clr_busy_ff;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_status     = stat_ff;
   assign rsp_read_value = 32'(signed'(res_ff));
endmodule

FILE: tb/sparse_csc_matrix_store_core_tb.sv
// Testbench for sparse_csc_matrix_store_core: drives reads and writes, predicts results
// with a behavioral CSC store, and checks each strobed result. Depends on scsc_pkg.
`timescale 1ns / 1ps
module sparse_csc_matrix_store_core_tb;
   localparam int NCOL = 1024;
   localparam int NENT = 4096;
   localparam int CYCLE_LIMIT = 100_000_000;

   typedef struct {
      logic signed [31:0] read_value;
      logic               status;
   } answer_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_action = scsc_pkg::ACT_READ;
   logic [9:0]         req_row = '0;
   logic [9:0]         req_column = '0;
   logic signed [31:0] req_value = '0;
   logic               rsp_strobe;
   logic signed [31:0] rsp_read_value;
   logic               rsp_status;

   sparse_csc_matrix_store_core dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   int unsigned        col_ptr [NCOL+1];
   logic [9:0]         row_at [NENT];
   logic signed [31:0] val_at [NENT];
   int unsigned        stored;

   answer_type  pending [$];
   int unsigned errors, transfers, checked, writes_full;
   longint      cycles = 0;

   function automatic answer_type csc_apply(logic act, logic [9:0] r, logic [9:0] c,
                                            logic signed [31:0] v);
      answer_type a;
      int unsigned lo, hi, pos;
      a.read_value = '0;
      a.status = scsc_pkg::STAT_DONE;
      lo = col_ptr[c];
      hi = col_ptr[c+1];
      if (hi > stored) hi = stored;
      if (act == scsc_pkg::ACT_READ) begin
         for (int i = lo; i < hi; i++)
            if (row_at[i] == r) begin
               a.read_value = val_at[i];
               break;
            end
      end else if (stored >= NENT) begin
         a.status = scsc_pkg::STAT_FULL;
         writes_full++;
      end else begin
         pos = hi;
         for (int i = lo; i < hi; i++)
            if (row_at[i] > r) begin
               pos = i;
               break;
            end
         for (int i = stored; i > pos; i--) begin
            row_at[i] = row_at[i-1];
            val_at[i] = val_at[i-1];
         end
         row_at[pos] = r;
         val_at[pos] = v;
         stored++;
         for (int i = c + 1; i <= NCOL; i++) col_ptr[i]++;
      end
      return a;
   endfunction

   task automatic report(string what);
      errors++;
      $display("ERROR @%0t: %s", $realtime, what);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("sparse_csc_matrix_store_core: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      answer_type e;
      if (!reset && rsp_strobe) begin
         checked++;
         if (pending.size() == 0) report("result with nothing expected");
         else begin
            e = pending.pop_front();
            if (rsp_read_value !== e.read_value)
               report($sformatf("read_value %0d, expected %0d", rsp_read_value,
                                e.read_value));
            if (rsp_status !== e.status)
               report($sformatf("status %0b, expected %0b", rsp_status, e.status));
         end
      end
   end

   // start rises only after the previous transfer has been taken, after a random idle
   // gap when gaps is set; the block is busy while it handles an item anyway
   task automatic send(logic act, logic [9:0] r, logic [9:0] c, logic signed [31:0] v,
                       bit gaps = 1);
      int unsigned idle;
      answer_type  exp;
      idle = gaps ? $urandom_range(0, 16) : 0;
      repeat (idle + 1) @(posedge clock);
      start <= 1'b1;
      req_action <= act;
      req_row <= r;
      req_column <= c;
      req_value <= v;
      do @(posedge clock); while (busy !== 1'b0);
      exp = csc_apply(act, r, c, v);
      pending = {pending, exp};
      transfers++;
      start <= 1'b0;
   endtask

   task automatic drain();
      while (pending.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send(scsc_pkg::ACT_READ, 10'd0, 10'd0, 0);
      send(scsc_pkg::ACT_WRITE, 10'd0, 10'd0, 32'sh7fffffff);
      send(scsc_pkg::ACT_WRITE, 10'd1023, 10'd1023, 32'sh80000000);
      send(scsc_pkg::ACT_WRITE, 10'd5, 10'd0, 0);
      send(scsc_pkg::ACT_WRITE, 10'd5, 10'd0, -1);
      send(scsc_pkg::ACT_WRITE, 10'd2, 10'd0, 17);
      send(scsc_pkg::ACT_READ, 10'd5, 10'd0, 0);
      send(scsc_pkg::ACT_READ, 10'd2, 10'd0, 0);
      send(scsc_pkg::ACT_READ, 10'd0, 10'd0, 0);
      send(scsc_pkg::ACT_READ, 10'd1023, 10'd1023, 0);
      send(scsc_pkg::ACT_READ, 10'd3, 10'd0, 0);
      send(scsc_pkg::ACT_READ, 10'd0, 10'd1, 0);
      send(scsc_pkg::ACT_WRITE, 10'h2aa, 10'h155, 32'sh55555555, 0);
      send(scsc_pkg::ACT_WRITE, 10'h155, 10'h2aa, 32'shaaaaaaaa, 0);
      send(scsc_pkg::ACT_READ, 10'h2aa, 10'h155, 0, 0);
      send(scsc_pkg::ACT_READ, 10'h155, 10'h2aa, 0, 0);
      drain();
   endtask

   // mostly small column/row sets so reads hit; some wide-range noise
   task automatic test_random(int unsigned n);
      logic [9:0] r, c;
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 3) != 0) begin
            r = 10'($urandom_range(0, 15));
            c = 10'($urandom_range(0, 31) * 32);
         end else begin
            r = 10'($urandom);
            c = 10'($urandom);
         end
         send(1'($urandom_range(0, 1)), r, c, $urandom, k % 200 < 150);
         if (k == n / 2) drain();
      end
      drain();
   endtask

   initial begin
      foreach (col_ptr[i]) col_ptr[i] = 0;
      stored = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(1900);
      repeat (3 * NENT) @(posedge clock);
      $display("covered %0d transfers, %0d results, %0d entries stored, %0d full rejects",
               transfers, checked, stored, writes_full);
      if (errors == 0 && pending.size() == 0)
         $display("sparse_csc_matrix_store_core: match");
      else
         $display("sparse_csc_matrix_store_core: mismatch");
      $finish;
   end
endmodule
